[hdl/cpi_pkg.sv]
// Shared types and constants for the curve point interpolator.
// Holds the opcode and state encodings and the fixed field widths.
// No dependencies.
package cpi_pkg;

  // Fixed widths of the item fields.
  localparam int unsigned OpW  = 2;
  localparam int unsigned IdxW = 8;
  localparam int unsigned LvlW = 8;

  // Configuration register index, taken from paddr[2].
  localparam logic REG_MODE = 1'b0;

  // Mode register encodings.
  localparam logic MODE_HOLD   = 1'b0;
  localparam logic MODE_LINEAR = 1'b1;

  typedef enum logic [OpW-1:0] {
    OP_SET   = 2'd0,
    OP_CLR   = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DOWN,
    ST_UP,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

[hdl/curve_point_interpolator.sv]
// Top level of the curve point interpolator: point memory, scan sequencer,
// a multiply and restoring divide step, and the APB mode register.
// Depends on cpi_pkg.
//
// Usage. Items enter on start/opcode_i/index_i/point_level_i and are taken
// at a clock edge where start is high and busy is low. Set and clear leave
// busy low. A query returns one result: result_valid_o is high for exactly
// one cycle with curve_value_o; the receiver cannot stall it and must take
// it in that cycle. A query outside the table answers 0 on the cycle after
// it is taken.
// Query timing is set by the single read port of the point memory, which
// visits one entry per cycle: a downward scan from the index to the nearest
// point, in linear mode an upward scan to the next point, then a multiply
// step, eight divide steps and an output step. Busy stays high from the
// accepting edge until the result is shown.
// After reset the block clears the point memory, one entry per cycle, with
// busy high; mode register writes are taken as ever.
// The mode register (APB, address 0) resets to linear mode.
module curve_point_interpolator
  import cpi_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic [OpW-1:0]  opcode_i,
  input  logic [IdxW-1:0] index_i,
  input  logic [LvlW-1:0] point_level_i,
  output logic            result_valid_o,
  output logic [LvlW-1:0] curve_value_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  localparam int unsigned AW = $clog2(TABLE_SIZE);
  localparam logic [AW-1:0] LAST = AW'(TABLE_SIZE - 1);

  state_e state_q, state_d;

  logic            mode_q;
  logic [AW-1:0]   clr_q, clr_d;
  logic [AW-1:0]   q_q, q_d;
  logic [AW-1:0]   scan_q, scan_d;
  logic            more_q, more_d;
  logic [AW-1:0]   prev_pos_q, prev_pos_d;
  logic [LvlW-1:0] prev_val_q, prev_val_d;
  logic [AW-1:0]   off_q, off_d;
  logic [AW-1:0]   gap_q, gap_d;
  logic [LvlW-1:0] mag_q, mag_d;
  logic            sign_q, sign_d;
  logic [AW-1:0]   rem_q, rem_d;
  logic [LvlW-1:0] low_q, low_d;
  logic [2:0]      cnt_q, cnt_d;
  logic            res_vld_q, res_vld_d;
  logic [LvlW-1:0] res_val_q, res_val_d;

  // Point memory: bit LvlW is the present flag.
  logic [LvlW:0]   point_mem_q [TABLE_SIZE];
  logic [LvlW:0]   rdata_q;
  logic            rd_vld_q;
  logic [AW-1:0]   rd_pos_q;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [LvlW:0]   wr_data;

  logic            accept;
  logic            in_table;
  logic [AW-1:0]   idx_addr;
  logic            rd_present;
  logic [LvlW-1:0] rd_level;
  logic            dn_hit;
  logic            up_hit;
  logic [LvlW-1:0] dn_val;
  logic [AW-1:0]   dn_pos;
  logic [AW:0]     div_t;
  logic            div_ge;

  assign accept     = start && !busy;
  assign in_table   = 32'(index_i) < TABLE_SIZE;
  assign idx_addr   = AW'(index_i);
  assign rd_present = rdata_q[LvlW];
  assign rd_level   = rdata_q[LvlW-1:0];

  // Scan outcomes: a point was seen, or the scan reached the table edge.
  assign dn_hit = rd_vld_q && (rd_present || rd_pos_q == '0);
  assign up_hit = rd_vld_q && (rd_present || rd_pos_q == LAST);
  assign dn_val = rd_present ? rd_level : '0;
  assign dn_pos = rd_present ? rd_pos_q : '0;

  // One restoring divide step: shift in the next dividend bit.
  assign div_t  = {rem_q, low_q[LvlW-1]};
  assign div_ge = div_t >= {1'b0, gap_q};

  assign busy           = state_q != ST_IDLE;
  assign result_valid_o = res_vld_q;
  assign curve_value_o  = res_val_q;
  assign pready         = 1'b1;

  // Mode register over APB.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_LINEAR;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MODE) begin
      mode_q <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MODE) begin
      prdata = {31'b0, mode_q};
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && opcode_i == OP_QUERY && in_table) begin
          state_d = ST_DOWN;
        end
      end
      ST_DOWN: begin
        if (dn_hit) begin
          if (mode_q == MODE_HOLD || (rd_present && rd_pos_q == q_q) || q_q == LAST) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_UP;
          end
        end
      end
      ST_UP: begin
        if (up_hit) begin
          state_d = rd_present ? ST_MUL : ST_IDLE;
        end
      end
      ST_MUL: state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == 3'd7) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    clr_d      = clr_q;
    q_d        = q_q;
    scan_d     = scan_q;
    more_d     = more_q;
    prev_pos_d = prev_pos_q;
    prev_val_d = prev_val_q;
    off_d      = off_q;
    gap_d      = gap_q;
    mag_d      = mag_q;
    sign_d     = sign_q;
    rem_d      = rem_q;
    low_d      = low_q;
    cnt_d      = cnt_q;
    res_vld_d  = 1'b0;
    res_val_d  = res_val_q;
    rd_en      = 1'b0;
    rd_addr    = scan_q;
    wr_en      = 1'b0;
    wr_addr    = idx_addr;
    wr_data    = {opcode_i == OP_SET, point_level_i};
    case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
        clr_d   = clr_q + 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          case (opcode_i)
            OP_SET, OP_CLR: begin
              wr_en = in_table;
            end
            OP_QUERY: begin
              if (in_table) begin
                q_d    = idx_addr;
                scan_d = idx_addr;
                more_d = 1'b1;
              end else begin
                res_vld_d = 1'b1;
                res_val_d = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DOWN: begin
        // Issue reads downward until a point is seen.
        rd_en = more_q && !dn_hit;
        if (rd_en) begin
          if (scan_q == '0) begin
            more_d = 1'b0;
          end else begin
            scan_d = scan_q - 1'b1;
          end
        end
        if (dn_hit) begin
          prev_pos_d = dn_pos;
          prev_val_d = dn_val;
          off_d      = q_q - dn_pos;
          scan_d     = q_q + 1'b1;
          more_d     = 1'b1;
          if (mode_q == MODE_HOLD || (rd_present && rd_pos_q == q_q) || q_q == LAST) begin
            res_vld_d = 1'b1;
            res_val_d = dn_val;
          end
        end
      end
      ST_UP: begin
        // Issue reads upward until the next point or the table end.
        rd_en = more_q && !up_hit;
        if (rd_en) begin
          if (scan_q == LAST) begin
            more_d = 1'b0;
          end else begin
            scan_d = scan_q + 1'b1;
          end
        end
        if (up_hit) begin
          gap_d  = rd_pos_q - prev_pos_q;
          sign_d = rd_level < prev_val_q;
          mag_d  = (rd_level < prev_val_q) ? prev_val_q - rd_level : rd_level - prev_val_q;
          if (!rd_present) begin
            res_vld_d = 1'b1;
            res_val_d = prev_val_q;
          end
        end
      end
      ST_MUL: begin
        // The product is below gap * 256, so its upper part starts the remainder.
        {rem_d, low_d} = {{LvlW{1'b0}}, off_q} * {{AW{1'b0}}, mag_q};
        cnt_d          = '0;
      end
      ST_DIV: begin
        rem_d = div_ge ? AW'(div_t - {1'b0, gap_q}) : div_t[AW-1:0];
        low_d = {low_q[LvlW-2:0], div_ge};
        cnt_d = cnt_q + 1'b1;
      end
      ST_OUT: begin
        res_vld_d = 1'b1;
        res_val_d = sign_q ? prev_val_q - low_q : prev_val_q + low_q;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      more_q    <= 1'b0;
      cnt_q     <= '0;
      res_vld_q <= 1'b0;
      rd_vld_q  <= 1'b0;
      rd_pos_q  <= '0;
      scan_q    <= '0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      more_q    <= more_d;
      cnt_q     <= cnt_d;
      res_vld_q <= res_vld_d;
      rd_vld_q  <= rd_en;
      rd_pos_q  <= rd_addr;
      scan_q    <= scan_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    q_q        <= q_d;
    prev_pos_q <= prev_pos_d;
    prev_val_q <= prev_val_d;
    off_q      <= off_d;
    gap_q      <= gap_d;
    mag_q      <= mag_d;
    sign_q     <= sign_d;
    rem_q      <= rem_d;
    low_q      <= low_d;
    res_val_q  <= res_val_d;
  end

  // Point memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      point_mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= point_mem_q[rd_addr];
    end
  end

  // Read data only returns while a scan is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == ST_DOWN || state_q == ST_UP))
    else $error("read data returned outside a scan");

  // A query outside the table answers on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && opcode_i == OP_QUERY && !in_table) |=> result_valid_o)
    else $error("outside query gave no result");

  // A result transfer always coincides with the sequencer being free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while busy");

  // The divider never runs with a zero divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (gap_q != '0))
    else $error("divide by zero gap");

  // The partial remainder stays below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < gap_q))
    else $error("divider remainder out of range");

endmodule
